// ----- src/flv_tag_stream_demux_unit_assert.svh -----
// Assertion macros for the FLV tag stream demux checker.
`ifndef FLV_TAG_STREAM_DEMUX_UNIT_ASSERT_SVH
`define FLV_TAG_STREAM_DEMUX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FLVDMX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flvdmx assertion failed");

// Next-cycle implication, disabled during reset.
`define FLVDMX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flvdmx assertion failed");

`endif

// ----- src/flvdmx_pkg.sv -----
// Package: types and codes shared by the FLV tag stream demux.
package flvdmx_pkg;

  localparam logic [7:0] TYPE_AUDIO  = 8'd8;
  localparam logic [7:0] TYPE_VIDEO  = 8'd9;
  localparam logic [7:0] TYPE_SCRIPT = 8'd18;

  localparam logic [1:0] ROUTE_DROP  = 2'd0;
  localparam logic [1:0] ROUTE_AUDIO = 2'd1;
  localparam logic [1:0] ROUTE_VIDEO = 2'd2;
  localparam logic [1:0] ROUTE_HEAD  = 2'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_TAG   = 2'd1;
  localparam logic [1:0] EV_AUDIO = 2'd2;
  localparam logic [1:0] EV_VIDEO = 2'd3;

  localparam logic [1:0] KIND_AUDIO  = 2'd0;
  localparam logic [1:0] KIND_VIDEO  = 2'd1;
  localparam logic [1:0] KIND_SCRIPT = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  localparam logic [0:0] REG_AUDIO_EN = 1'd0;
  localparam logic [0:0] REG_VIDEO_EN = 1'd1;

  localparam logic [31:0] HEAD_MIN_LEN = 32'd9;
  localparam logic [31:0] HEAD_OFS_POS = 32'd5;
  localparam logic [31:0] HEAD_LAST    = 32'd8;
  localparam logic [31:0] PREV_LAST    = 32'd3;
  localparam logic [31:0] SIZE_LAST    = 32'd3;
  localparam logic [31:0] TIME_LAST    = 32'd6;
  localparam logic [31:0] TAGH_LAST    = 32'd10;

  typedef struct packed {
    logic audio_en;
    logic video_en;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  video_codec;
    logic [3:0]  video_frame;
    logic        audio_stereo;
    logic        audio_wide;
    logic [1:0]  audio_rate;
    logic [3:0]  audio_format;
    logic [23:0] tag_time;
    logic [23:0] tag_size;
    logic [1:0]  tag_kind;
    logic [1:0]  event_res;
    logic [1:0]  route;
    logic [7:0]  out_byte;
  } res_t;

endpackage

// ----- src/flvdmx_parse.sv -----
// Parser state and single-pass next-state / result logic for one byte.
module flvdmx_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [7:0]         in_byte,
  input  logic               file_start,
  input  flvdmx_pkg::cfg_t   cfg,
  output flvdmx_pkg::res_t   res
);
  import flvdmx_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_SKIP = 3'd1,
    PH_PREV = 3'd2,
    PH_TAGH = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t      phase, phase_next, ph_cur;
  logic [31:0] byte_count, byte_count_next, bc_cur;
  logic [31:0] header_offset, header_offset_next, ho_cur;
  logic [7:0]  cur_type, cur_type_next, ty_cur;
  logic [23:0] cur_size, cur_size_next, sz_cur;
  logic [23:0] cur_time, cur_time_next, tm_cur;
  logic        after_video, after_video_next, av_cur;
  logic [32:0] bc_inc;

  always_comb begin
    if (file_start) begin
      ph_cur = PH_HEAD;
      bc_cur = '0;
      ho_cur = '0;
      ty_cur = '0;
      sz_cur = '0;
      tm_cur = '0;
      av_cur = 1'b0;
    end else begin
      ph_cur = phase;
      bc_cur = byte_count;
      ho_cur = header_offset;
      ty_cur = cur_type;
      sz_cur = cur_size;
      tm_cur = cur_time;
      av_cur = after_video;
    end
  end

  assign bc_inc = {1'b0, bc_cur} + 33'd1;

  always_comb begin
    phase_next         = ph_cur;
    byte_count_next    = bc_cur;
    header_offset_next = ho_cur;
    cur_type_next      = ty_cur;
    cur_size_next      = sz_cur;
    cur_time_next      = tm_cur;
    after_video_next   = av_cur;
    res                = '0;
    res.out_byte       = in_byte;

    unique case (ph_cur)
      PH_SKIP: begin
        res.route = ROUTE_HEAD;
        if (bc_inc >= {1'b0, ho_cur}) begin
          phase_next      = PH_PREV;
          byte_count_next = '0;
        end else begin
          byte_count_next = bc_inc[31:0];
        end
      end
      PH_PREV: begin
        res.route = (av_cur && cfg.video_en) ? ROUTE_VIDEO : ROUTE_DROP;
        if (bc_cur >= PREV_LAST) begin
          after_video_next = 1'b0;
          phase_next       = PH_TAGH;
          byte_count_next  = '0;
        end else begin
          byte_count_next = bc_inc[31:0];
        end
      end
      PH_TAGH: begin
        if (bc_cur == '0) begin
          cur_type_next = in_byte;
        end else if (bc_cur <= SIZE_LAST) begin
          cur_size_next = {sz_cur[15:0], in_byte};
        end else if (bc_cur <= TIME_LAST) begin
          cur_time_next = {tm_cur[15:0], in_byte};
        end
        res.route = (cur_type_next == TYPE_VIDEO && cfg.video_en) ? ROUTE_VIDEO : ROUTE_DROP;
        if (bc_cur >= TAGH_LAST) begin
          res.event_res   = EV_TAG;
          byte_count_next = '0;
          if (cur_size_next == '0) begin
            after_video_next = (cur_type_next == TYPE_VIDEO);
            phase_next       = PH_PREV;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          byte_count_next = bc_inc[31:0];
        end
      end
      PH_DATA: begin
        if (ty_cur == TYPE_AUDIO) begin
          if (bc_cur == '0) begin
            res.event_res    = EV_AUDIO;
            res.audio_format = in_byte[7:4];
            res.audio_rate   = in_byte[3:2];
            res.audio_wide   = in_byte[1];
            res.audio_stereo = in_byte[0];
          end else if (cfg.audio_en) begin
            res.route = ROUTE_AUDIO;
          end
        end else if (ty_cur == TYPE_VIDEO) begin
          if (bc_cur == '0) begin
            res.event_res   = EV_VIDEO;
            res.video_frame = in_byte[7:4];
            res.video_codec = in_byte[3:0];
          end
          res.route = cfg.video_en ? ROUTE_VIDEO : ROUTE_DROP;
        end
        if (bc_inc >= {9'd0, sz_cur}) begin
          after_video_next = (ty_cur == TYPE_VIDEO);
          phase_next       = PH_PREV;
          byte_count_next  = '0;
        end else begin
          byte_count_next = bc_inc[31:0];
        end
      end
      default: begin
        res.route = ROUTE_HEAD;
        if (bc_cur >= HEAD_OFS_POS) begin
          header_offset_next = {ho_cur[23:0], in_byte};
        end
        if (bc_cur >= HEAD_LAST) begin
          if (header_offset_next > HEAD_MIN_LEN) begin
            phase_next      = PH_SKIP;
            byte_count_next = HEAD_MIN_LEN;
          end else begin
            phase_next      = PH_PREV;
            byte_count_next = '0;
          end
        end else begin
          byte_count_next = bc_inc[31:0];
        end
      end
    endcase

    if (cur_type_next == TYPE_AUDIO) begin
      res.tag_kind = KIND_AUDIO;
    end else if (cur_type_next == TYPE_VIDEO) begin
      res.tag_kind = KIND_VIDEO;
    end else if (cur_type_next == TYPE_SCRIPT) begin
      res.tag_kind = KIND_SCRIPT;
    end else begin
      res.tag_kind = KIND_OTHER;
    end
    res.tag_size = cur_size_next;
    res.tag_time = cur_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      byte_count    <= '0;
      header_offset <= '0;
      cur_type      <= '0;
      cur_size      <= '0;
      cur_time      <= '0;
      after_video   <= 1'b0;
    end else if (adv) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      header_offset <= header_offset_next;
      cur_type      <= cur_type_next;
      cur_size      <= cur_size_next;
      cur_time      <= cur_time_next;
      after_video   <= after_video_next;
    end
  end

endmodule

// ----- src/flv_tag_stream_demux_unit.sv -----
// Top level: FLV tag stream demux, one file byte per beat in, one tagged byte per beat out.
// Takes an FLV file one byte per beat and returns each byte with its route (drop, audio
// payload, video stream, file header), a parse event, the current tag kind, size and
// timestamp, and the decoded audio or video info on the first data byte of a tag. Each
// accepted byte yields exactly one result beat, in the next cycle, from the result register;
// one byte is taken every clock while the result side keeps up, the rate being set by the
// combinational parse step. s_tuser marks the first byte of a file and restarts the parse.
// No clearing pass follows reset. The enables are sampled per byte and take effect at once.
module flv_tag_stream_demux_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_tuser,   // [0] file_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_byte, [31:8] tag_size, [55:32] tag_time, [59:56] audio_format,
  // [61:60] audio_rate, [62] audio_wide, [63] audio_stereo, [67:64] video_frame,
  // [71:68] video_codec
  output logic [71:0] m_tdata,
  output logic [5:0]  m_tuser,   // [1:0] route, [3:2] event_res, [5:4] tag_kind
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data
);
  import flvdmx_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic adv;

  assign s_tready = !m_tvalid || m_tready;
  assign adv      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.audio_en <= 1'b1;
      cfg.video_en <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUDIO_EN: cfg.audio_en <= cfg_data[0];
        REG_VIDEO_EN: cfg.video_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  flvdmx_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_byte    (s_tdata),
    .file_start (s_tuser[0]),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.video_codec, res_q.video_frame, res_q.audio_stereo,
                    res_q.audio_wide, res_q.audio_rate, res_q.audio_format,
                    res_q.tag_time, res_q.tag_size, res_q.out_byte};
  assign m_tuser = {res_q.tag_kind, res_q.event_res, res_q.route};

endmodule

// ----- src/flvdmx_chk.sv -----
// Port-level checker for the FLV tag stream demux, bound to the top level.
`include "flv_tag_stream_demux_unit_assert.svh"

module flvdmx_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [5:0]  m_tuser
);
  import flvdmx_pkg::*;

  logic [1:0] route;
  logic [1:0] ev;
  logic [1:0] kind;
  logic       m_stall;
  logic       s_beat;
  logic [7:0] audio_info;
  logic [7:0] video_info;
  logic       audio_ok;
  logic       video_ok;

  assign route      = m_tuser[1:0];
  assign ev         = m_tuser[3:2];
  assign kind       = m_tuser[5:4];
  assign m_stall    = m_tvalid && !m_tready;
  assign s_beat     = s_tvalid && s_tready;
  assign audio_info = m_tdata[63:56];
  assign video_info = m_tdata[71:64];
  assign audio_ok   = kind == KIND_AUDIO && route == ROUTE_DROP && video_info == 8'd0;
  assign video_ok   = kind == KIND_VIDEO && audio_info == 8'd0;

  // a stalled result beat holds
  `FLVDMX_ASSERT_NEXT(a_hold, clk, rst, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // an accepted byte comes out in the next cycle
  `FLVDMX_ASSERT_NEXT(a_pass, clk, rst, s_beat, m_tvalid && m_tdata[7:0] == $past(s_tdata))

  // audio info only on a dropped byte of an audio tag
  `FLVDMX_ASSERT_NOW(a_audio_ev, clk, rst, m_tvalid && ev == EV_AUDIO, audio_ok)

  // video info only within a video tag
  `FLVDMX_ASSERT_NOW(a_video_ev, clk, rst, m_tvalid && ev == EV_VIDEO, video_ok)

  // file header bytes carry no event
  `FLVDMX_ASSERT_NOW(a_head_ev, clk, rst, m_tvalid && route == ROUTE_HEAD, ev == EV_NONE)

endmodule

bind flv_tag_stream_demux_unit flvdmx_chk u_flvdmx_chk (.*);
